[rtl/assert_macros.svh]
// Assertion helper macros for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/iatb_pkg.sv]
// ----------------------------------------------------------------------------
// iatb_pkg
// Shared types and constants for the interface adapter timer block.
// ----------------------------------------------------------------------------
package iatb_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [3:0] REG_ORB  = 4'd0;
    localparam logic [3:0] REG_ORA  = 4'd1;
    localparam logic [3:0] REG_DDRB = 4'd2;
    localparam logic [3:0] REG_DDRA = 4'd3;
    localparam logic [3:0] REG_T1CL = 4'd4;
    localparam logic [3:0] REG_T1CH = 4'd5;
    localparam logic [3:0] REG_T1LL = 4'd6;
    localparam logic [3:0] REG_T1LH = 4'd7;
    localparam logic [3:0] REG_T2CL = 4'd8;
    localparam logic [3:0] REG_T2CH = 4'd9;
    localparam logic [3:0] REG_SR   = 4'd10;
    localparam logic [3:0] REG_ACR  = 4'd11;
    localparam logic [3:0] REG_PCR  = 4'd12;
    localparam logic [3:0] REG_IFR  = 4'd13;
    localparam logic [3:0] REG_IER  = 4'd14;
    localparam logic [3:0] REG_ORAN = 4'd15;

    localparam int DIV_W = 17;

    // Divider control and status
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  rem;
    } div_rsp_t;

endpackage

[rtl/iatb_divider.sv]
// ----------------------------------------------------------------------------
// iatb_divider
// Restoring bit-serial remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module iatb_divider
    import iatb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[DIV_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    `ASSERT_NEXT(a_div_done, clk, rst_n, busy_reg && cnt_reg == CW'(1), done_reg, "divider did not finish")
    `ASSERT_IMPL(a_div_idle, clk, rst_n, done_reg, !busy_reg, "divider done while busy")
    `ASSERT_IMPL(a_div_rem, clk, rst_n, done_reg, rem_reg < dsr_reg, "remainder not below divisor")

endmodule

[rtl/interface_adapter_timer_block_unit.sv]
// ----------------------------------------------------------------------------
// interface_adapter_timer_block_unit
// Interface adapter register file with two 16-bit down-counting timers.
// ----------------------------------------------------------------------------
// Each transfer is a bus read, a bus write, a batched tick or an unused
// command that only clears the read data, and the block works on one
// transfer at a time. A transfer is taken in the idle state and executed in
// the next cycle. Its result then waits in the output register until it is
// taken. Reads, writes, unused commands, zero ticks, and ticks that do not
// wrap timer 1 in continuous mode offer their result in the cycle after
// execution; with no output stall, it transfers in the cycle it is offered.
// A tick that wraps timer 1 in continuous mode finds the reload position with
// the 17-bit restoring remainder unit, which produces one bit a cycle. The
// block launches the unit, waits while it iterates over all 17 dividend
// bits, writes the counter when the unit reports done, and then offers its
// result. The next transfer is taken the cycle after the result leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module interface_adapter_timer_block_unit
    import iatb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [3:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [15:0] tick_cycles,
    input  logic [7:0]  port_a_pins,
    input  logic [7:0]  port_b_pins,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        irq
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;
    localparam logic [6:0] FLAG_T1 = 7'h40;
    localparam logic [6:0] FLAG_T2 = 7'h20;

    logic [1:0]  state_reg, state_next;
    logic [7:0]  pa_out_reg, pb_out_reg, pa_dir_reg, pb_dir_reg;
    logic [7:0]  sr_reg, acr_reg, pcr_reg;
    logic [6:0]  ifr_reg, ier_reg;
    logic [7:0]  t1ll_reg, t1lh_reg, t2ll_reg;
    logic [15:0] t1c_reg, t2c_reg;
    logic        t1a_reg, t2a_reg;
    // captured transfer
    logic [1:0]  cmd_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  wd_reg, pa_reg, pb_reg;
    logic [15:0] cyc_reg;
    logic [7:0]  rd_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    iatb_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic [15:0] l1;
    logic [16:0] t1_to, t2_to, t1_rest;
    logic        tick, t1_hit, t2_hit, t1_cont;

    assign l1      = {t1lh_reg, t1ll_reg};
    assign tick    = cmd_reg == CMD_TICK && cyc_reg != 16'd0;
    assign t1_to   = {1'b0, t1c_reg} + 17'd1;
    assign t2_to   = {1'b0, t2c_reg} + 17'd1;
    assign t1_hit  = {1'b0, cyc_reg} >= t1_to;
    assign t2_hit  = {1'b0, cyc_reg} >= t2_to;
    assign t1_rest = {1'b0, cyc_reg} - t1_to;
    assign t1_cont = acr_reg[6];

    always_comb
    begin
        div_req.start    = state_reg == ST_EXEC && tick && t1_hit && t1_cont;
        div_req.dividend = t1_rest;
        div_req.divisor  = {1'b0, l1} + 17'd1;
    end

    function automatic logic [7:0] mix(input logic [7:0] o, input logic [7:0] d,
                                       input logic [7:0] p);
        mix = (o & d) | (p & ~d);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = div_req.start ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_rsp.done) state_next = ST_OUT;
            default: if (!out_stall) state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pa_out_reg <= '0; pb_out_reg <= '0; pa_dir_reg <= '0; pb_dir_reg <= '0;
            sr_reg <= '0; acr_reg <= '0; pcr_reg <= '0;
            ifr_reg <= '0; ier_reg <= '0;
            t1ll_reg <= '0; t1lh_reg <= '0; t2ll_reg <= '0;
            t1c_reg <= '0; t2c_reg <= '0; t1a_reg <= 1'b0; t2a_reg <= 1'b0;
            rd_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV && div_rsp.done)
                t1c_reg <= 16'(l1 - div_rsp.rem[15:0]);
            if (state_reg == ST_EXEC)
            begin
                if (cmd_reg != CMD_READ)
                    rd_reg <= '0;
                if (cmd_reg == CMD_READ)
                begin
                    unique case (idx_reg)
                        REG_ORB:  rd_reg <= mix(pb_out_reg, pb_dir_reg, pb_reg);
                        REG_ORA, REG_ORAN: rd_reg <= mix(pa_out_reg, pa_dir_reg, pa_reg);
                        REG_DDRB: rd_reg <= pb_dir_reg;
                        REG_DDRA: rd_reg <= pa_dir_reg;
                        REG_T1CL:
                        begin
                            rd_reg  <= t1c_reg[7:0];
                            ifr_reg <= ifr_reg & ~FLAG_T1;
                        end
                        REG_T1CH: rd_reg <= t1c_reg[15:8];
                        REG_T1LL: rd_reg <= t1ll_reg;
                        REG_T1LH: rd_reg <= t1lh_reg;
                        REG_T2CL:
                        begin
                            rd_reg  <= t2c_reg[7:0];
                            ifr_reg <= ifr_reg & ~FLAG_T2;
                        end
                        REG_T2CH: rd_reg <= t2c_reg[15:8];
                        REG_SR:   rd_reg <= sr_reg;
                        REG_ACR:  rd_reg <= acr_reg;
                        REG_PCR:  rd_reg <= pcr_reg;
                        REG_IFR:  rd_reg <= {|(ifr_reg & ier_reg), ifr_reg};
                        default:  rd_reg <= {1'b1, ier_reg};
                    endcase
                end
                else if (cmd_reg == CMD_WRITE)
                begin
                    unique case (idx_reg)
                        REG_ORB:  pb_out_reg <= wd_reg;
                        REG_ORA, REG_ORAN: pa_out_reg <= wd_reg;
                        REG_DDRB: pb_dir_reg <= wd_reg;
                        REG_DDRA: pa_dir_reg <= wd_reg;
                        REG_T1CL, REG_T1LL: t1ll_reg <= wd_reg;
                        REG_T1CH:
                        begin
                            t1lh_reg <= wd_reg;
                            t1c_reg  <= {wd_reg, t1ll_reg};
                            t1a_reg  <= 1'b1;
                            ifr_reg  <= ifr_reg & ~FLAG_T1;
                        end
                        REG_T1LH:
                        begin
                            t1lh_reg <= wd_reg;
                            ifr_reg  <= ifr_reg & ~FLAG_T1;
                        end
                        REG_T2CL: t2ll_reg <= wd_reg;
                        REG_T2CH:
                        begin
                            t2c_reg <= {wd_reg, t2ll_reg};
                            t2a_reg <= 1'b1;
                            ifr_reg <= ifr_reg & ~FLAG_T2;
                        end
                        REG_SR:   sr_reg <= wd_reg;
                        REG_ACR:  acr_reg <= wd_reg;
                        REG_PCR:  pcr_reg <= wd_reg;
                        REG_IFR:  ifr_reg <= ifr_reg & ~wd_reg[6:0];
                        default:
                            if (wd_reg[7]) ier_reg <= ier_reg | wd_reg[6:0];
                            else           ier_reg <= ier_reg & ~wd_reg[6:0];
                    endcase
                end
                else if (tick)
                begin
                    // timer 1: continuous wrap finishes in the divider
                    if (!t1_hit)
                        t1c_reg <= 16'(t1c_reg - cyc_reg);
                    else if (!t1_cont)
                        t1c_reg <= 16'hFFFF - t1_rest[15:0];
                    if (t1_hit && !t1_cont)
                        t1a_reg <= 1'b0;
                    if (!t2_hit)
                        t2c_reg <= 16'(t2c_reg - cyc_reg);
                    else
                    begin
                        t2c_reg <= 16'hFFFF - 16'(cyc_reg - t2_to[15:0]);
                        t2a_reg <= 1'b0;
                    end
                    ifr_reg <= ifr_reg | ((t1_hit && t1a_reg) ? FLAG_T1 : 7'h0)
                                       | ((t2_hit && t2a_reg) ? FLAG_T2 : 7'h0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            cmd_reg <= command;
            idx_reg <= reg_index;
            wd_reg  <= write_data;
            cyc_reg <= tick_cycles;
            pa_reg  <= port_a_pins;
            pb_reg  <= port_b_pins;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign read_data = rd_reg;
    assign irq       = |(ifr_reg & ier_reg);

    `ASSERT_IMPL(a_one_busy, clk, rst_n, out_valid, in_stall, "accepted while result pending")
    `ASSERT_NEXT(a_div_run, clk, rst_n, div_req.start,
                 state_reg == ST_DIV && div_rsp.busy, "divider not started")
    `ASSERT_IMPL(a_div_state, clk, rst_n, div_rsp.busy, state_reg == ST_DIV,
                 "divider busy outside wait")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interface adapter timer block: a queue-fed
// driver, a scoreboard monitor and a behavioural predictor of registers,
// timers and interrupt flags, run through phases of source and sink idling.
// ----------------------------------------------------------------------------
module tb;
    import iatb_pkg::*;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  reg_index;
        logic [7:0]  write_data;
        logic [15:0] tick_cycles;
        logic [7:0]  port_a_pins;
        logic [7:0]  port_b_pins;
    } bus_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } bus_result_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [3:0]  reg_index;
    logic [7:0]  write_data;
    logic [15:0] tick_cycles;
    logic [7:0]  port_a_pins;
    logic [7:0]  port_b_pins;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        irq;

    interface_adapter_timer_block_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .reg_index(reg_index), .write_data(write_data),
        .tick_cycles(tick_cycles), .port_a_pins(port_a_pins),
        .port_b_pins(port_b_pins),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_data(read_data), .irq(irq)
    );

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state, a private copy of the adapter's registers
    // ------------------------------------------------------------------
    logic [7:0]  m_ora, m_orb, m_ddra, m_ddrb, m_sr, m_acr, m_pcr;
    logic [6:0]  m_ifr, m_ier;
    logic [7:0]  m_t1ll, m_t1lh, m_t2ll;
    logic [15:0] m_t1c, m_t2c;
    logic        m_t1_armed, m_t2_armed;

    bus_item_t   pending_items[$];
    bus_result_t expected_results[$];

    int  err_count;
    int  sent_count;
    int  seen_count;
    int  idle_src_pct;
    int  idle_snk_pct;
    bit  hold_src;
    int  quiet_cycles;
    int  ticks_sent, reads_sent, writes_sent;

    function automatic logic [7:0] port_mix(logic [7:0] o, logic [7:0] d, logic [7:0] p);
        return (o & d) | (p & ~d);
    endfunction

    // Counter advance: returns 1 when an armed timer fires.
    task automatic count_down(inout logic [15:0] cnt, inout logic armed,
                              input logic cont, input logic [16:0] latch,
                              input logic [16:0] cyc, output logic fired);
        logic [16:0] span;
        logic [16:0] rest;
        begin
            fired = 1'b0;
            span = {1'b0, cnt} + 17'd1;
            if (cyc < span)
                cnt = cnt - cyc[15:0];
            else
            begin
                if (armed)
                begin
                    fired = 1'b1;
                    if (!cont)
                        armed = 1'b0;
                end
                rest = cyc - span;
                if (cont)
                    cnt = 16'(latch - (rest % (latch + 17'd1)));
                else
                    cnt = 16'hFFFF - rest[15:0];
            end
        end
    endtask

    // Apply one transfer to the predictor and return what the bus shows after it.
    task automatic predict_access(input bus_item_t it, output bus_result_t res);
        logic [7:0] data;
        logic       f1, f2;
        begin
            data = 8'h00;
            if (it.command == CMD_READ)
            begin
                case (it.reg_index)
                    REG_ORB:  data = port_mix(m_orb, m_ddrb, it.port_b_pins);
                    REG_ORA, REG_ORAN: data = port_mix(m_ora, m_ddra, it.port_a_pins);
                    REG_DDRB: data = m_ddrb;
                    REG_DDRA: data = m_ddra;
                    REG_T1CL:
                    begin
                        data = m_t1c[7:0];
                        m_ifr[6] = 1'b0;
                    end
                    REG_T1CH: data = m_t1c[15:8];
                    REG_T1LL: data = m_t1ll;
                    REG_T1LH: data = m_t1lh;
                    REG_T2CL:
                    begin
                        data = m_t2c[7:0];
                        m_ifr[5] = 1'b0;
                    end
                    REG_T2CH: data = m_t2c[15:8];
                    REG_SR:   data = m_sr;
                    REG_ACR:  data = m_acr;
                    REG_PCR:  data = m_pcr;
                    REG_IFR:  data = {|(m_ifr & m_ier), m_ifr};
                    default:  data = {1'b1, m_ier};
                endcase
            end
            else if (it.command == CMD_WRITE)
            begin
                case (it.reg_index)
                    REG_ORB:  m_orb = it.write_data;
                    REG_ORA, REG_ORAN: m_ora = it.write_data;
                    REG_DDRB: m_ddrb = it.write_data;
                    REG_DDRA: m_ddra = it.write_data;
                    REG_T1CL, REG_T1LL: m_t1ll = it.write_data;
                    REG_T1CH:
                    begin
                        m_t1lh = it.write_data;
                        m_t1c = {it.write_data, m_t1ll};
                        m_t1_armed = 1'b1;
                        m_ifr[6] = 1'b0;
                    end
                    REG_T1LH:
                    begin
                        m_t1lh = it.write_data;
                        m_ifr[6] = 1'b0;
                    end
                    REG_T2CL: m_t2ll = it.write_data;
                    REG_T2CH:
                    begin
                        m_t2c = {it.write_data, m_t2ll};
                        m_t2_armed = 1'b1;
                        m_ifr[5] = 1'b0;
                    end
                    REG_SR:   m_sr = it.write_data;
                    REG_ACR:  m_acr = it.write_data;
                    REG_PCR:  m_pcr = it.write_data;
                    REG_IFR:  m_ifr = m_ifr & ~it.write_data[6:0];
                    default:
                        if (it.write_data[7])
                            m_ier = m_ier | it.write_data[6:0];
                        else
                            m_ier = m_ier & ~it.write_data[6:0];
                endcase
            end
            else if (it.command == CMD_TICK && it.tick_cycles != 16'd0)
            begin
                count_down(m_t1c, m_t1_armed, m_acr[6], {1'b0, m_t1lh, m_t1ll},
                           {1'b0, it.tick_cycles}, f1);
                count_down(m_t2c, m_t2_armed, 1'b0, 17'd0, {1'b0, it.tick_cycles}, f2);
                if (f1) m_ifr[6] = 1'b1;
                if (f2) m_ifr[5] = 1'b1;
            end
            res.read_data = data;
            res.irq = |(m_ifr & m_ier);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the oldest pending item, holds it while stalled.
    // The predictor runs at the accepting edge, so expectations stay in order.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t res;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            command     <= CMD_READ;
            reg_index   <= REG_ORB;
            write_data  <= 8'h00;
            tick_cycles <= 16'h0000;
            port_a_pins <= 8'h00;
            port_b_pins <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_access(pending_items[0], res);
                expected_results.push_back(res);
                void'(pending_items.pop_front());
                sent_count++;
            end
            // valid is held whenever an item was shown and not yet taken
            if (in_valid && in_stall)
                ;
            else if (pending_items.size() != 0 && !hold_src &&
                     $urandom_range(99) >= idle_src_pct)
            begin
                in_valid    <= 1'b1;
                command     <= pending_items[0].command;
                reg_index   <= pending_items[0].reg_index;
                write_data  <= pending_items[0].write_data;
                tick_cycles <= pending_items[0].tick_cycles;
                port_a_pins <= pending_items[0].port_a_pins;
                port_b_pins <= pending_items[0].port_b_pins;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bus_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: read_data=%0h irq=%0b",
                           read_data, irq);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $error("read_data expected %02h actual %02h", want.read_data, read_data);
                        err_count++;
                    end
                    if (irq !== want.irq)
                    begin
                        $error("irq expected %0b actual %0b", want.irq, irq);
                        err_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_snk_pct);
        end
    end

    // Watchdog on cycles with no transfer on either side, paused while the source is held
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (!hold_src)
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("interface_adapter_timer_block_unit test failed");
                $finish;
            end
        end
    end

    function automatic bus_item_t make_item(logic [1:0] c, logic [3:0] r, logic [7:0] d,
                                            logic [15:0] t);
        bus_item_t it;
        it.command     = c;
        it.reg_index   = r;
        it.write_data  = d;
        it.tick_cycles = t;
        it.port_a_pins = 8'($urandom);
        it.port_b_pins = 8'($urandom);
        return it;
    endfunction

    // Random reads, writes, ticks and unused commands, with ticks biased toward short counts
    function automatic bus_item_t random_item();
        int         sel;
        logic [3:0] r;
        logic [15:0] t;
        sel = $urandom_range(99);
        r = 4'($urandom);
        if ($urandom_range(9) < 4)
            t = 16'($urandom_range(300));
        else if ($urandom_range(9) < 7)
            t = 16'($urandom_range(3000));
        else
            t = 16'($urandom);
        if (sel < 35)
            return make_item(CMD_READ, r, 8'($urandom), 16'($urandom));
        else if (sel < 65)
            return make_item(CMD_WRITE, r, 8'($urandom), 16'($urandom));
        else if (sel < 97)
            return make_item(CMD_TICK, r, 8'($urandom), t);
        else
            return make_item(2'd3, r, 8'($urandom), 16'($urandom));
    endfunction

    task automatic run_phase(input int n, input int src_pct, input int snk_pct);
        bus_item_t it;
        begin
            idle_src_pct = src_pct;
            idle_snk_pct = snk_pct;
            for (int i = 0; i < n; i++)
            begin
                it = random_item();
                if (it.command == CMD_TICK) ticks_sent++;
                else if (it.command == CMD_READ) reads_sent++;
                else if (it.command == CMD_WRITE) writes_sent++;
                pending_items.push_back(it);
            end
            wait (pending_items.size() == 0);
        end
    endtask

    initial
    begin
        m_ora = 0; m_orb = 0; m_ddra = 0; m_ddrb = 0; m_sr = 0; m_acr = 0; m_pcr = 0;
        m_ifr = 0; m_ier = 0; m_t1ll = 0; m_t1lh = 0; m_t2ll = 0;
        m_t1c = 0; m_t2c = 0; m_t1_armed = 0; m_t2_armed = 0;
        err_count = 0; sent_count = 0; seen_count = 0;
        idle_src_pct = 0; idle_snk_pct = 0; hold_src = 0;
        quiet_cycles = 0; ticks_sent = 0; reads_sent = 0; writes_sent = 0;
        in_valid = 0; command = CMD_READ; reg_index = REG_ORB; write_data = 0;
        tick_cycles = 0; port_a_pins = 0; port_b_pins = 0; out_stall = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;

        // Directed: enable all, program both timers, one-shot and continuous
        // underflow, multiple periods in one tick, zero tick, flag clearing
        pending_items.push_back(make_item(CMD_WRITE, REG_IER, 8'hFF, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_DDRA, 8'hF0, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_ORA, 8'hA5, 16'd0));
        pending_items.push_back(make_item(CMD_READ, REG_ORAN, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_T1LL, 8'h05, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_T1CH, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_TICK, REG_ORB, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_TICK, REG_ORB, 8'h00, 16'd6));
        pending_items.push_back(make_item(CMD_READ, REG_IFR, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_READ, REG_T1CL, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_ACR, 8'h40, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_T1CH, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_TICK, REG_ORB, 8'h00, 16'hFFFF));
        pending_items.push_back(make_item(CMD_READ, REG_T1CH, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_T1LH, 8'hFF, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_T2CL, 8'hFF, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_T2CH, 8'hFF, 16'd0));
        pending_items.push_back(make_item(CMD_TICK, REG_ORB, 8'h00, 16'hFFFF));
        pending_items.push_back(make_item(CMD_TICK, REG_ORB, 8'h00, 16'd1));
        pending_items.push_back(make_item(CMD_READ, REG_T2CL, 8'h00, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_IFR, 8'hFF, 16'd0));
        pending_items.push_back(make_item(CMD_WRITE, REG_IER, 8'h3F, 16'd0));
        pending_items.push_back(make_item(CMD_READ, REG_IER, 8'h00, 16'd0));
        pending_items.push_back(make_item(2'd3, REG_SR, 8'hFF, 16'hFFFF));
        wait (pending_items.size() == 0);

        run_phase(500, 0, 0);
        // sender holds off until the block has drained
        hold_src = 1'b1;
        wait (expected_results.size() == 0);
        hold_src = 1'b0;
        run_phase(500, 79, 0);
        run_phase(500, 0, 79);
        run_phase(500, 23, 23);

        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);
        $display("covered %0d transfers (%0d reads, %0d writes, %0d ticks), %0d results",
                 sent_count, reads_sent, writes_sent, ticks_sent, seen_count);
        $display("idling phases: none, source 79%%, sink 79%%, both 23%%");
        if (err_count == 0 && expected_results.size() == 0)
            $display("interface_adapter_timer_block_unit test passed");
        else
            $display("interface_adapter_timer_block_unit test failed");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/iatb_pkg.sv
rtl/iatb_divider.sv
rtl/interface_adapter_timer_block_unit.sv
tb/tb.sv
